// ===== hdl/eds_pkg.sv =====
// shared constants and helpers for the euclidean distance block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package eds_pkg;

	localparam int FP_W = 32;

	localparam logic [FP_W-1:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [FP_W-1:0] PINF_BITS = 32'h7F80_0000;

	// leading zero count of a 48-bit word, 48 when the word is zero
	function automatic logic [5:0] lzc48(input logic [47:0] w);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (w[i]) begin
				n = 6'(47 - i);
			end
		end
		return n;
	endfunction

	function automatic logic is_nan(input logic [FP_W-1:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/eds_pair_if.sv =====
// input channel: one element pair per item
// depends on eds_pkg
`timescale 1ns / 1ps
`default_nettype none

interface eds_pair_if;
	logic                     valid;
	logic                     ready;
	logic [eds_pkg::FP_W-1:0] element_a;
	logic [eds_pkg::FP_W-1:0] element_b;
	logic                     last_element;

	modport source(output valid, output element_a, output element_b, output last_element,
		input ready);
	modport sink(input valid, input element_a, input element_b, input last_element,
		output ready);
endinterface

`default_nettype wire

// ===== hdl/eds_dist_if.sv =====
// output channel: one distance per vector
// depends on eds_pkg
`timescale 1ns / 1ps
`default_nettype none

interface eds_dist_if;
	logic                     valid;
	logic                     ready;
	logic [eds_pkg::FP_W-1:0] distance;

	modport source(output valid, output distance, input ready);
	modport sink(input valid, input distance, output ready);
endinterface

`default_nettype wire

// ===== hdl/euclidean_distance_single.sv =====
// euclidean distance of two single-precision vectors, top level
// depends on eds_pkg, eds_pair_if, eds_dist_if
`timescale 1ns / 1ps
`default_nettype none

// Takes one pair of binary32 elements per item and accumulates (a - b)^2 into a
// running sum, each of subtract, square and add rounded to nearest even in
// element order. On the item flagged last_element it returns the correctly
// rounded square root of the sum as distance and clears the sum. Subtract, square
// and add all go through one shared datapath: an align/add front, a 24x24
// multiplier, a normalizer (leading zero count, then shift) and one rounding/pack
// stage, driven by a small sequencer. An ordinary item is accepted, then passes
// through subtract, square and accumulate; the last item then takes a square
// root, which is a restoring root producing one bit per cycle. pairs.ready is
// high only while the sequencer is idle. The distance sits in an output register,
// so the next vector may start while it waits to be taken. NaNs come out as
// 0x7FC00000, subnormals are fully supported.
module euclidean_distance_single (
	input  wire        clk,
	input  wire        arst_n,
	eds_pair_if.sink   pairs,
	eds_dist_if.source result
);

	// sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_ALIGN   = 4'd1;
	localparam logic [3:0] S_SUM     = 4'd2;
	localparam logic [3:0] S_MUL     = 4'd3;
	localparam logic [3:0] S_NORM1   = 4'd4;
	localparam logic [3:0] S_NORM2   = 4'd5;
	localparam logic [3:0] S_ROUND   = 4'd6;
	localparam logic [3:0] S_SQ_INIT = 4'd7;
	localparam logic [3:0] S_SQ_ITER = 4'd8;
	localparam logic [3:0] S_SQ_DONE = 4'd9;

	// which operation of the item is in the float datapath
	localparam logic [1:0] PH_SUB = 2'd0;
	localparam logic [1:0] PH_MUL = 2'd1;
	localparam logic [1:0] PH_ACC = 2'd2;

	localparam logic [4:0] SQ_LAST = 5'd25;

	logic [3:0]  state_q;
	logic [1:0]  phase_q;
	logic        last_q;
	logic [31:0] sum_q;
	logic [31:0] opx_q, opy_q;

	// float datapath registers
	logic [26:0]        mbig_q, msml_q;
	logic               eff_sub_q, sgn_q, zsgn_q, spec_q, zero_q;
	logic [31:0]        specv_q;
	logic signed [10:0] exp_q;
	logic [47:0]        w_q;
	logic [5:0]         lz_q;
	logic [26:0]        m27_q;

	// square root registers
	logic [31:0]       sqx_q;
	logic [51:0]       rad_q;
	logic [27:0]       rem_q;
	logic [25:0]       root_q;
	logic signed [9:0] k_q;
	logic [4:0]        cnt_q;
	logic              sqspec_q;
	logic [31:0]       sqv_q;

	// output register
	logic        outv_q;
	logic [31:0] dist_q;

	assign pairs.ready     = (state_q == S_IDLE);
	assign result.valid    = outv_q;
	assign result.distance = dist_q;

	// ---------------- align front ----------------
	logic        a_xbig, a_nanx, a_nany, a_infx, a_infy;
	logic [31:0] a_big, a_sml;
	logic [7:0]  a_eb, a_es, a_dd;
	logic [4:0]  a_sh;
	logic [55:0] a_ext;
	logic        a_spec;
	logic [31:0] a_specv;

	always_comb begin
		a_nanx = eds_pkg::is_nan(opx_q);
		a_nany = eds_pkg::is_nan(opy_q);
		a_infx = (opx_q[30:0] == eds_pkg::PINF_BITS[30:0]);
		a_infy = (opy_q[30:0] == eds_pkg::PINF_BITS[30:0]);
		a_xbig = (opx_q[30:0] >= opy_q[30:0]);
		a_big  = a_xbig ? opx_q : opy_q;
		a_sml  = a_xbig ? opy_q : opx_q;
		a_eb   = (a_big[30:23] == 8'd0) ? 8'd1 : a_big[30:23];
		a_es   = (a_sml[30:23] == 8'd0) ? 8'd1 : a_sml[30:23];
		a_dd   = a_eb - a_es;
		a_sh   = (a_dd > 8'd31) ? 5'd31 : a_dd[4:0];
		a_ext  = {a_sml[30:23] != 8'd0, a_sml[22:0], 32'd0} >> a_sh;
		a_spec  = 1'b1;
		a_specv = eds_pkg::QNAN_BITS;
		if (a_nanx || a_nany) begin
			a_specv = eds_pkg::QNAN_BITS;
		end else if (a_infx && a_infy && (opx_q[31] != opy_q[31])) begin
			a_specv = eds_pkg::QNAN_BITS;
		end else if (a_infx) begin
			a_specv = {opx_q[31], eds_pkg::PINF_BITS[30:0]};
		end else if (a_infy) begin
			a_specv = {opy_q[31], eds_pkg::PINF_BITS[30:0]};
		end else begin
			a_spec = 1'b0;
		end
	end

	// ---------------- multiplier front ----------------
	logic        m_nanx, m_nany, m_infx, m_infy, m_zx, m_zy, m_spec;
	logic [31:0] m_specv;
	logic [7:0]  m_ex, m_ey;

	always_comb begin
		m_nanx = eds_pkg::is_nan(opx_q);
		m_nany = eds_pkg::is_nan(opy_q);
		m_infx = (opx_q[30:0] == eds_pkg::PINF_BITS[30:0]);
		m_infy = (opy_q[30:0] == eds_pkg::PINF_BITS[30:0]);
		m_zx   = (opx_q[30:0] == 31'd0);
		m_zy   = (opy_q[30:0] == 31'd0);
		m_ex   = (opx_q[30:23] == 8'd0) ? 8'd1 : opx_q[30:23];
		m_ey   = (opy_q[30:23] == 8'd0) ? 8'd1 : opy_q[30:23];
		m_spec  = 1'b1;
		m_specv = eds_pkg::QNAN_BITS;
		if (m_nanx || m_nany || (m_infx && m_zy) || (m_infy && m_zx)) begin
			m_specv = eds_pkg::QNAN_BITS;
		end else if (m_infx || m_infy) begin
			m_specv = {opx_q[31] ^ opy_q[31], eds_pkg::PINF_BITS[30:0]};
		end else begin
			m_spec = 1'b0;
		end
	end

	// ---------------- adder, normalizer ----------------
	logic [27:0] s_sum;
	logic [47:0] n_ws;

	assign s_sum = eff_sub_q ? ({1'b0, mbig_q} - {1'b0, msml_q})
		: ({1'b0, mbig_q} + {1'b0, msml_q});
	assign n_ws  = w_q << lz_q;

	// ---------------- rounding and packing ----------------
	logic               r_den;
	logic signed [10:0] r_amt11, r_ef;
	logic [4:0]         r_amt;
	logic [53:0]        r_ext;
	logic [26:0]        r_mm;
	logic               r_inc;
	logic [24:0]        r_v;
	logic [31:0]        r_pk, r_out, r_canon;

	always_comb begin
		r_den   = (exp_q <= 11'sd0);
		r_amt11 = 11'sd1 - exp_q;
		r_amt   = 5'd0;
		if (r_den) begin
			r_amt = (r_amt11 > 11'sd27) ? 5'd27 : r_amt11[4:0];
		end
		r_ext = {m27_q, 27'd0} >> r_amt;
		r_mm  = r_ext[53:27] | {26'd0, |r_ext[26:0]};
		r_inc = r_mm[2] & (r_mm[3] | r_mm[1] | r_mm[0]);
		r_v   = {1'b0, r_mm[26:3]} + {24'd0, r_inc};
		r_ef  = exp_q + {10'd0, r_v[24]};
		if (r_den) begin
			// subnormal, a carry into the hidden bit gives the smallest normal
			r_pk = {sgn_q, 7'd0, r_v[23], r_v[22:0]};
		end else if (r_ef >= 11'sd255) begin
			r_pk = {sgn_q, eds_pkg::PINF_BITS[30:0]};
		end else begin
			r_pk = {sgn_q, r_ef[7:0], r_v[24] ? 23'd0 : r_v[22:0]};
		end
		if (spec_q) begin
			r_out = specv_q;
		end else if (zero_q) begin
			r_out = {zsgn_q, 31'd0};
		end else begin
			r_out = r_pk;
		end
		r_canon = eds_pkg::is_nan(r_out) ? eds_pkg::QNAN_BITS : r_out;
	end

	// ---------------- square root setup and step ----------------
	logic              q_spec;
	logic [31:0]       q_specv;
	logic [5:0]        q_lz6;
	logic [4:0]        q_lz;
	logic [23:0]       q_mn;
	logic signed [9:0] q_k;
	logic [24:0]       q_m25;
	logic [29:0]       q_r2, q_t;
	logic              q_ge;

	always_comb begin
		q_spec  = 1'b1;
		q_specv = sqx_q;
		if (eds_pkg::is_nan(sqx_q)) begin
			q_specv = eds_pkg::QNAN_BITS;
		end else if (sqx_q[30:0] == 31'd0) begin
			q_specv = sqx_q;
		end else if (sqx_q[31]) begin
			q_specv = eds_pkg::QNAN_BITS;
		end else if (sqx_q[30:23] == 8'hFF) begin
			q_specv = eds_pkg::PINF_BITS;
		end else begin
			q_spec = 1'b0;
		end
		q_lz6 = eds_pkg::lzc48({1'b0, sqx_q[22:0], 24'd0});
		q_lz  = 5'd0;
		if (sqx_q[30:23] == 8'd0) begin
			q_lz = q_lz6[4:0];
			q_mn = {1'b0, sqx_q[22:0]} << q_lz;
			q_k  = -10'sd149 - signed'({5'd0, q_lz});
		end else begin
			q_mn = {1'b1, sqx_q[22:0]};
			q_k  = signed'({2'd0, sqx_q[30:23]}) - 10'sd150;
		end
		// even exponent so the root exponent halves exactly
		if (q_k[0]) begin
			q_m25 = {q_mn, 1'b0};
			q_k   = q_k - 10'sd1;
		end else begin
			q_m25 = {1'b0, q_mn};
		end
		q_r2 = {rem_q, rad_q[51:50]};
		q_t  = {2'd0, root_q, 2'b01};
		q_ge = (q_r2 >= q_t);
	end

	// ---------------- square root rounding ----------------
	logic              d_sh1, d_up;
	logic [1:0]        d_low, d_half;
	logic [23:0]       d_qq;
	logic [24:0]       d_qr;
	logic signed [9:0] d_ef;
	logic [31:0]       d_out;

	always_comb begin
		d_sh1  = ~root_q[25];
		d_low  = d_sh1 ? {1'b0, root_q[0]} : root_q[1:0];
		d_half = d_sh1 ? 2'd1 : 2'd2;
		d_qq   = d_sh1 ? root_q[24:1] : root_q[25:2];
		d_up   = (d_low > d_half)
			|| ((d_low == d_half) && ((rem_q != 28'd0) || d_qq[0]));
		d_qr   = {1'b0, d_qq} + {24'd0, d_up};
		d_ef   = (k_q >>> 1) + 10'sd137 + (d_sh1 ? 10'sd1 : 10'sd2)
			+ signed'({9'd0, d_qr[24]});
		d_out  = {1'b0, d_ef[7:0], d_qr[24] ? 23'd0 : d_qr[22:0]};
		if (sqspec_q) begin
			d_out = sqv_q;
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_SUB;
			sum_q   <= 32'd0;
			outv_q  <= 1'b0;
		end else begin
			// a distance loaded this cycle keeps the valid set
			if (outv_q && result.ready && (state_q != S_SQ_DONE)) begin
				outv_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pairs.valid) begin
						// a - b as a + (-b)
						opx_q   <= pairs.element_a;
						opy_q   <= {~pairs.element_b[31], pairs.element_b[30:0]};
						last_q  <= pairs.last_element;
						phase_q <= PH_SUB;
						state_q <= S_ALIGN;
					end
				end
				S_ALIGN: begin
					mbig_q    <= {a_big[30:23] != 8'd0, a_big[22:0], 3'd0};
					msml_q    <= a_ext[55:29] | {26'd0, |a_ext[28:0]};
					eff_sub_q <= a_big[31] ^ a_sml[31];
					sgn_q     <= a_big[31];
					zsgn_q    <= opx_q[31] & opy_q[31];
					exp_q     <= signed'({3'd0, a_eb});
					spec_q    <= a_spec;
					specv_q   <= a_specv;
					state_q   <= S_SUM;
				end
				S_SUM: begin
					w_q     <= {s_sum, 20'd0};
					state_q <= S_NORM1;
				end
				S_MUL: begin
					w_q     <= {opx_q[30:23] != 8'd0, opx_q[22:0]}
						* {opy_q[30:23] != 8'd0, opy_q[22:0]};
					exp_q   <= signed'({3'd0, m_ex}) + signed'({3'd0, m_ey}) - 11'sd127;
					sgn_q   <= opx_q[31] ^ opy_q[31];
					zsgn_q  <= opx_q[31] ^ opy_q[31];
					spec_q  <= m_spec;
					specv_q <= m_specv;
					state_q <= S_NORM1;
				end
				S_NORM1: begin
					lz_q    <= eds_pkg::lzc48(w_q);
					zero_q  <= (w_q == 48'd0);
					state_q <= S_NORM2;
				end
				S_NORM2: begin
					// leading one lands on bit 26 of the rounding word
					m27_q   <= n_ws[47:21] | {26'd0, |n_ws[20:0]};
					exp_q   <= exp_q + 11'sd1 - signed'({5'd0, lz_q});
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					case (phase_q)
						PH_SUB: begin
							opx_q   <= r_out;
							opy_q   <= r_out;
							phase_q <= PH_MUL;
							state_q <= S_MUL;
						end
						PH_MUL: begin
							opx_q   <= sum_q;
							opy_q   <= r_out;
							phase_q <= PH_ACC;
							state_q <= S_ALIGN;
						end
						default: begin
							if (last_q) begin
								sqx_q   <= r_canon;
								sum_q   <= 32'd0;
								state_q <= S_SQ_INIT;
							end else begin
								sum_q   <= r_canon;
								state_q <= S_IDLE;
							end
						end
					endcase
				end
				S_SQ_INIT: begin
					sqspec_q <= q_spec;
					sqv_q    <= q_specv;
					rad_q    <= {1'b0, q_m25, 26'd0};
					k_q      <= q_k;
					rem_q    <= 28'd0;
					root_q   <= 26'd0;
					cnt_q    <= 5'd0;
					state_q  <= S_SQ_ITER;
				end
				S_SQ_ITER: begin
					// one root bit per cycle
					rad_q  <= {rad_q[49:0], 2'd0};
					rem_q  <= q_ge ? 28'(q_r2 - q_t) : q_r2[27:0];
					root_q <= {root_q[24:0], q_ge};
					cnt_q  <= cnt_q + 5'd1;
					if (cnt_q == SQ_LAST) begin
						state_q <= S_SQ_DONE;
					end
				end
				S_SQ_DONE: begin
					if (!outv_q || result.ready) begin
						dist_q  <= d_out;
						outv_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb_eds_checker.sv =====
// checker for the euclidean distance block: watches both channels, predicts every distance
// with its own bit-exact binary32 arithmetic and compares it with what comes out
// depends on eds_pkg, eds_pair_if, eds_dist_if
`timescale 1ns / 1ps

module tb_eds_checker (
	input  wire  clk,
	input  wire  arst_n,
	eds_pair_if  pairs,
	eds_dist_if  result,
	output int   fail_count,
	output int   pending,
	output int   pair_count,
	output int   dist_count,
	output int   special_count
);

	localparam logic [31:0] POS_ZERO = 32'h0000_0000;

	logic [31:0] run_sum;
	logic [31:0] dist_q[$];

	function automatic logic nan_bits(input logic [31:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
	endfunction

	function automatic logic inf_bits(input logic [31:0] x);
		return x[30:0] == 31'h7F80_0000;
	endfunction

	// value = m * 2^e
	function automatic void split_fp(input logic [31:0] x, output logic [23:0] m, output int e);
		if (x[30:23] == 8'd0) begin
			m = {1'b0, x[22:0]};
			e = -149;
		end else begin
			m = {1'b1, x[22:0]};
			e = int'(x[30:23]) - 150;
		end
	endfunction

	// round (m + sticky fraction) * 2^e to nearest even and pack
	function automatic logic [31:0] round_pack(input logic sgn, input logic [65:0] m, input int e,
		input logic sticky);
		int p;
		int sh;
		int lsb_e;
		logic [65:0] q;
		logic [65:0] low;
		logic [65:0] half;
		if (m == 66'd0) begin
			return {sgn, 31'd0};
		end
		p = 0;
		for (int i = 0; i < 66; i++) begin
			if (m[i]) begin
				p = i;
			end
		end
		sh = p - 23;
		if (sh < -149 - e) begin
			sh = -149 - e;
		end
		if (sh > 65) begin
			return {sgn, 31'd0};
		end
		if (sh <= 0) begin
			q = m << (-sh);
		end else begin
			q = m >> sh;
			low = m & ((66'd1 << sh) - 66'd1);
			half = 66'd1 << (sh - 1);
			if (low > half || (low == half && (sticky || q[0]))) begin
				q = q + 66'd1;
			end
		end
		if (q[24]) begin
			q = q >> 1;
			sh = sh + 1;
		end
		lsb_e = e + sh;
		if (!q[23]) begin
			return {sgn, 8'd0, q[22:0]};
		end
		if (lsb_e + 150 >= 255) begin
			return {sgn, eds_pkg::PINF_BITS[30:0]};
		end
		return {sgn, 8'(lsb_e + 150), q[22:0]};
	endfunction

	function automatic logic [31:0] fp_sum(input logic [31:0] x, input logic [31:0] y);
		logic [31:0] big;
		logic [31:0] sml;
		logic [23:0] mb;
		logic [23:0] ms;
		int eb;
		int es;
		int diff;
		logic [65:0] wa;
		logic [65:0] wb;
		logic [65:0] wfull;
		logic [65:0] s;
		logic st;
		if (nan_bits(x) || nan_bits(y)) begin
			return eds_pkg::QNAN_BITS;
		end
		if (inf_bits(x) && inf_bits(y) && x[31] != y[31]) begin
			return eds_pkg::QNAN_BITS;
		end
		if (inf_bits(x)) begin
			return x;
		end
		if (inf_bits(y)) begin
			return y;
		end
		big = x;
		sml = y;
		if (y[30:0] > x[30:0]) begin
			big = y;
			sml = x;
		end
		if (big[30:0] == 31'd0) begin
			return {x[31] & y[31], 31'd0};
		end
		split_fp(big, mb, eb);
		split_fp(sml, ms, es);
		diff = eb - es;
		wa = 66'(mb) << 40;
		wfull = 66'(ms) << 40;
		if (diff >= 66) begin
			wb = 66'd0;
			st = (ms != 24'd0);
		end else begin
			wb = wfull >> diff;
			st = ((wb << diff) != wfull);
		end
		if (big[31] == sml[31]) begin
			s = wa + wb;
		end else begin
			// truncated part of the smaller operand pulls the result just below wa - wb
			s = wa - wb - 66'(st);
		end
		if (s == 66'd0 && !st) begin
			return POS_ZERO;
		end
		return round_pack(big[31], s, eb - 40, st);
	endfunction

	function automatic logic [31:0] fp_prod(input logic [31:0] x, input logic [31:0] y);
		logic [23:0] mx;
		logic [23:0] my;
		int ex;
		int ey;
		logic sgn;
		sgn = x[31] ^ y[31];
		if (nan_bits(x) || nan_bits(y)) begin
			return eds_pkg::QNAN_BITS;
		end
		if (inf_bits(x) || inf_bits(y)) begin
			if (x[30:0] == 31'd0 || y[30:0] == 31'd0) begin
				return eds_pkg::QNAN_BITS;
			end
			return {sgn, eds_pkg::PINF_BITS[30:0]};
		end
		if (x[30:0] == 31'd0 || y[30:0] == 31'd0) begin
			return {sgn, 31'd0};
		end
		split_fp(x, mx, ex);
		split_fp(y, my, ey);
		return round_pack(sgn, 66'(48'(mx) * 48'(my)), ex + ey, 1'b0);
	endfunction

	// digit-by-digit root with a round-to-nearest-even decision on the remainder
	function automatic logic [31:0] fp_root(input logic [31:0] x);
		longint unsigned m;
		longint unsigned rem;
		longint unsigned res;
		longint unsigned bw;
		longint unsigned q;
		longint unsigned low;
		longint unsigned half;
		int k;
		int p;
		int sh;
		if (nan_bits(x)) begin
			return eds_pkg::QNAN_BITS;
		end
		if (x[30:0] == 31'd0) begin
			return x;
		end
		if (x[31]) begin
			return eds_pkg::QNAN_BITS;
		end
		if (x[30:23] == 8'hFF) begin
			return eds_pkg::PINF_BITS;
		end
		if (x[30:23] == 8'd0) begin
			m = longint'(x[22:0]);
			k = -149;
			while (m[23] == 1'b0) begin
				m = m << 1;
				k = k - 1;
			end
		end else begin
			m = longint'({1'b1, x[22:0]});
			k = int'(x[30:23]) - 150;
		end
		if (k % 2 != 0) begin
			m = m << 1;
			k = k - 1;
		end
		rem = m << 26;
		res = 0;
		bw = 64'd1 << 50;
		while (bw > rem) begin
			bw = bw >> 2;
		end
		while (bw != 0) begin
			if (rem >= res + bw) begin
				rem = rem - (res + bw);
				res = (res >> 1) + bw;
			end else begin
				res = res >> 1;
			end
			bw = bw >> 2;
		end
		sh = (res < (64'd1 << 25)) ? 1 : 2;
		low = res & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		q = res >> sh;
		if (low > half || (low == half && (rem != 0 || q[0]))) begin
			q = q + 1;
		end
		p = (k - 26) / 2 + sh;
		if (q >= (64'd1 << 24)) begin
			q = q >> 1;
			p = p + 1;
		end
		return {1'b0, 8'(p + 150), q[22:0]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] diff;
		logic [31:0] sum_next;
		logic [31:0] want;
		if (!arst_n) begin
			run_sum <= POS_ZERO;
			dist_q.delete();
			fail_count <= 0;
			pending <= 0;
			pair_count <= 0;
			dist_count <= 0;
			special_count <= 0;
		end else begin
			// the result side goes first: a distance taken now belongs to an earlier vector
			if (result.valid && result.ready) begin
				dist_count <= dist_count + 1;
				if (dist_q.size() == 0) begin
					$error("distance 0x%08h arrived with no vector outstanding", result.distance);
					fail_count <= fail_count + 1;
				end else begin
					want = dist_q.pop_front();
					if (want[30:23] == 8'hFF) begin
						special_count <= special_count + 1;
					end
					if (result.distance !== want) begin
						$error("distance: expected 0x%08h, got 0x%08h", want, result.distance);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (pairs.valid && pairs.ready) begin
				pair_count <= pair_count + 1;
				diff = fp_sum(pairs.element_a, {~pairs.element_b[31], pairs.element_b[30:0]});
				sum_next = fp_sum(run_sum, fp_prod(diff, diff));
				if (pairs.last_element) begin
					dist_q.push_back(fp_root(sum_next));
					run_sum <= POS_ZERO;
				end else begin
					run_sum <= sum_next;
				end
			end
			pending <= dist_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// testbench top for euclidean_distance_single: drives element pairs, throttles the
// distance channel and gives the verdict
// depends on eds_pkg, eds_pair_if, eds_dist_if, tb_eds_checker and the block itself
`timescale 1ns / 1ps

module tb_top;

	localparam int WATCHDOG_LIMIT = 4000; // cycles with no handshake on either channel
	localparam int DRAIN_CYCLES   = 80;   // wait after the last distance, with slack over the longest item
	localparam int HOLD_CYCLES    = 300;  // long receiver hold-off
	localparam int PHASE_ITEMS    = 220;

	logic clk;
	logic arst_n;

	eds_pair_if pairs_if();
	eds_dist_if dist_if();

	int fail_count;
	int pending;
	int pair_count;
	int dist_count;
	int special_count;

	// per-phase throttling, in percent
	int send_idle_pct;
	int recv_stall_pct;
	logic hold_req;
	int idle_cnt;

	euclidean_distance_single u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pairs(pairs_if),
		.result(dist_if)
	);

	tb_eds_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.pairs(pairs_if),
		.result(dist_if),
		.fail_count(fail_count),
		.pending(pending),
		.pair_count(pair_count),
		.dist_count(dist_count),
		.special_count(special_count)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// every input known from time zero, reset released at a falling edge
	initial begin
		arst_n = 1'b0;
		pairs_if.valid = 1'b0;
		pairs_if.element_a = '0;
		pairs_if.element_b = '0;
		pairs_if.last_element = 1'b0;
		dist_if.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// receiver: random stalls, plus a long hold-off on request counted here
	always @(negedge clk) begin
		if (!arst_n) begin
			dist_if.ready = 1'b0;
		end else if (hold_req) begin
			dist_if.ready = 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_req = 1'b0;
		end else begin
			dist_if.ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: nothing accepted for too long means the block hung
	always @(posedge clk) begin
		if (!arst_n || (pairs_if.valid && pairs_if.ready) || (dist_if.valid && dist_if.ready)) begin
			idle_cnt <= 0;
		end else begin
			idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d distances outstanding",
					WATCHDOG_LIMIT, pending);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// offer one item at the falling edge and hold it until the block takes it
	task automatic send_pair(input logic [31:0] a, input logic [31:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			pairs_if.valid = 1'b0;
			@(negedge clk);
		end
		pairs_if.valid = 1'b1;
		pairs_if.element_a = a;
		pairs_if.element_b = b;
		pairs_if.last_element = last;
		do begin
			@(posedge clk);
		end while (!pairs_if.ready);
		@(negedge clk);
		pairs_if.valid = 1'b0;
	endtask

	// mostly ordinary magnitudes, with subnormals, zeros, extremes and raw bit patterns mixed in
	function automatic logic [31:0] pick_element();
		int r;
		r = $urandom_range(99);
		if (r < 2) begin
			return {1'($urandom), 8'hFF, ($urandom_range(1) != 0) ? 23'($urandom) : 23'd0};
		end else if (r < 14) begin
			return $urandom;
		end else if (r < 24) begin
			return {1'($urandom), 8'd0, 23'($urandom)};
		end else if (r < 29) begin
			return {1'($urandom), 31'd0};
		end else if (r < 37) begin
			return {1'($urandom), 8'($urandom_range(254, 190)), 23'($urandom)};
		end else if (r < 47) begin
			return {1'($urandom), 8'($urandom_range(40, 1)), 23'($urandom)};
		end
		return {1'($urandom), 8'($urandom_range(134, 118)), 23'($urandom)};
	endfunction

	// one vector of random length; b sometimes sits right next to a to force cancellation
	task automatic send_vector(output int n_sent);
		int len;
		logic [31:0] a;
		logic [31:0] b;
		len = ($urandom_range(9) < 7) ? $urandom_range(6, 1) : $urandom_range(20, 7);
		for (int i = 0; i < len; i++) begin
			a = pick_element();
			b = ($urandom_range(99) < 15) ? (a ^ 32'($urandom_range(15))) : pick_element();
			send_pair(a, b, i == len - 1);
		end
		n_sent = len;
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input logic with_hold);
		int sent;
		int n;
		logic held;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		held = 1'b0;
		while (sent < PHASE_ITEMS) begin
			// long receiver hold-off partway through, sender keeps offering items
			if (with_hold && !held && sent >= PHASE_ITEMS / 2) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			send_vector(n);
			sent = sent + n;
		end
	endtask

	initial begin
		hold_req = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(posedge arst_n);
		@(negedge clk);

		// directed: zeros, signed zero, ordinary sum, overflow, nan and inf paths,
		// subnormals, near-cancellation, sum overflowing to infinity
		send_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
		send_pair(32'h8000_0000, 32'h0000_0000, 1'b1);
		send_pair(32'h3F80_0000, 32'h0000_0000, 1'b0);
		send_pair(32'h0000_0000, 32'h4000_0000, 1'b1);
		send_pair(32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b1);
		send_pair(32'h7F80_0000, 32'h7F80_0000, 1'b1);
		send_pair(32'h7FC1_2345, 32'h0000_0000, 1'b0);
		send_pair(32'h3F80_0000, 32'h0000_0000, 1'b1);
		send_pair(32'h0000_0001, 32'h0000_0000, 1'b1);
		send_pair(32'h0080_0000, 32'h0000_0000, 1'b0);
		send_pair(32'h1FFF_FFFF, 32'h0000_0000, 1'b1);
		send_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
		send_pair(32'h3F80_0001, 32'h3F80_0000, 1'b1);
		send_pair(32'hFF80_0000, 32'h0000_0000, 1'b1);
		send_pair(32'h1F80_0000, 32'h8000_0000, 1'b1);
		send_pair(32'h5F80_0000, 32'h0000_0000, 1'b0);
		send_pair(32'h5F80_0000, 32'h0000_0000, 1'b1);
		send_pair(32'h007F_FFFF, 32'h807F_FFFF, 1'b1);
		send_pair(32'h4049_0FDB, 32'hC02D_F854, 1'b1);

		// sender pause: let every outstanding distance come back
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		run_phase(0, 0, 1'b1);
		run_phase(68, 0, 1'b0);
		run_phase(0, 68, 1'b0);
		run_phase(33, 33, 1'b0);

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d element pairs and %0d distances, %0d of them nan or infinity,",
			pair_count, dist_count, special_count);
		$display("with sender gaps, receiver stalls and a long output hold-off");
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/eds_pkg.sv
hdl/eds_pair_if.sv
hdl/eds_dist_if.sv
hdl/euclidean_distance_single.sv
tb/tb_eds_checker.sv
tb/tb_top.sv
